>>> design/sdft_pkg.sv
// ----------------------------------------------------------------------------
// sdft_pkg
// Shared types, widths, twiddle table and saturation helpers for the
// sliding DFT bin update.
// ----------------------------------------------------------------------------
package sdft_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned BIN_W    = 40;
  localparam int unsigned TW_W     = 16;
  localparam int unsigned PROD_W   = BIN_W + TW_W;
  localparam int unsigned ACC_W    = PROD_W + 1;
  localparam int unsigned FRAC_SH  = 16;
  localparam int unsigned Q_SH     = 15;

  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_e;

  typedef struct packed {
    logic    valid;
    logic    dst_im;
    mac_op_e op;
  } mac_ctl_t;

  localparam logic signed [TW_W-1:0] QUARTER_SINE [17] = '{
    16'sd0,     16'sd3212,  16'sd6393,  16'sd9512,  16'sd12540, 16'sd15447,
    16'sd18205, 16'sd20788, 16'sd23170, 16'sd25330, 16'sd27246, 16'sd28899,
    16'sd30274, 16'sd31357, 16'sd32138, 16'sd32610, 16'sd32767
  };

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-BIN_W+1){1'b0}}, {(BIN_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-BIN_W+1){1'b1}}, {(BIN_W-1){1'b0}}};

  // sine of p sixty-fourths of a turn, Q1.15
  function automatic logic signed [TW_W-1:0] sine64(input logic [5:0] p);
    logic [1:0]              quad;
    logic [3:0]              r;
    logic signed [TW_W-1:0]  v;
    quad = p[5:4];
    r    = p[3:0];
    v    = quad[0] ? QUARTER_SINE[5'd16 - {1'b0, r}] : QUARTER_SINE[{1'b0, r}];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [BIN_W-1:0] sat_bin(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[BIN_W-1:0];
  endfunction

endpackage

>>> design/sdft_cmac.sv
// ----------------------------------------------------------------------------
// sdft_cmac
// Shared signed multiplier with registered product and two accumulators,
// real and imaginary, with Q15 round-half-up and 40-bit saturation.
// ----------------------------------------------------------------------------
module sdft_cmac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sdft_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [sdft_pkg::BIN_W-1:0]   x_i,
  input  logic signed [sdft_pkg::TW_W-1:0]    y_i,
  output logic signed [sdft_pkg::BIN_W-1:0]   re_o,
  output logic signed [sdft_pkg::BIN_W-1:0]   im_o
);
  import sdft_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  mac_ctl_t                 ctl_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_re_d;
  logic signed [ACC_W-1:0]  acc_im_q, acc_im_d;
  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_d   = x_i * y_i;
  assign prod_ext = ACC_W'(prod_q);
  assign acc_sel  = ctl_q.dst_im ? acc_im_q : acc_re_q;

  always_comb begin
    case (ctl_q.op)
      MAC_LOAD: acc_new = prod_ext;
      MAC_ADD:  acc_new = acc_sel + prod_ext;
      MAC_SUB:  acc_new = acc_sel - prod_ext;
      default:  acc_new = acc_sel;
    endcase
  end

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (ctl_q.valid) begin
      if (ctl_q.dst_im) begin
        acc_im_d = acc_new;
      end else begin
        acc_re_d = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, dst_im: 1'b0, op: MAC_LOAD};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
  end

  function automatic logic signed [BIN_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(1 << (Q_SH - 1));
    return sat_bin(t >>> Q_SH);
  endfunction

  assign re_o = round_q15(acc_re_q);
  assign im_o = round_q15(acc_im_q);

endmodule

>>> design/sliding_dft_update.sv
// ----------------------------------------------------------------------------
// sliding_dft_update
// Sliding DFT bin update: ring of the last WINDOW_SIZE samples, per-bin
// add of the new-minus-oldest difference and rotation by a fixed twiddle.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | in_valid_i / in_ready_o  | sample_i
//  output   | out_valid_o / out_ready_i| bin_index_o bin_real_o bin_imag_o
//           |                          | last_bin_o
//
//  each bin steps through prep, the multiply states, drain, round and output,
//  as the single shared multiplier does the four real products of each bin's
//  complex rotation one after another.
//  in_ready_o is high only between samples; the bins leave in order 0..N-1.
//  a stalled output holds the sequencer on the current bin.
//  reset clears ring, pointer and bins at once; no startup pass.
// ----------------------------------------------------------------------------
module sliding_dft_update #(
  parameter int unsigned WINDOW_SIZE = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [sdft_pkg::SAMPLE_W-1:0]          sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [sdft_pkg::IDX_W-1:0]             bin_index_o,
  output logic signed [sdft_pkg::BIN_W-1:0]      bin_real_o,
  output logic signed [sdft_pkg::BIN_W-1:0]      bin_imag_o,
  output logic                                   last_bin_o
);
  import sdft_pkg::*;

  localparam int unsigned KW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(WINDOW_SIZE - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_MUL0  = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_MUL3  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_ROUND = 9'b010000000,
    S_OUT   = 9'b100000000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] ptr_q;

  logic [SAMPLE_W-1:0]      ring_q [WINDOW_SIZE];
  logic signed [BIN_W-1:0]  bre_q  [WINDOW_SIZE];
  logic signed [BIN_W-1:0]  bim_q  [WINDOW_SIZE];
  logic signed [TW_W-1:0]   cos_rom [WINDOW_SIZE];
  logic signed [TW_W-1:0]   sin_rom [WINDOW_SIZE];

  logic signed [SAMPLE_W:0] delta_q;
  logic signed [BIN_W-1:0]  a_q, b_q;
  logic signed [TW_W-1:0]   c_q, d_q;
  logic signed [BIN_W-1:0]  res_re_q, res_im_q;

  logic                     in_xfer;
  logic                     out_xfer;
  logic signed [ACC_W-1:0]  add_sum;
  mac_ctl_t                 mac_ctl;
  logic signed [BIN_W-1:0]  mac_x;
  logic signed [TW_W-1:0]   mac_y;
  logic signed [BIN_W-1:0]  mac_re, mac_im;
  logic [KW+IDX_W-1:0]      k_wide;

  for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_twiddle
    localparam int unsigned PHASE = (g * 64) / WINDOW_SIZE;
    assign sin_rom[g] = sine64(6'(PHASE));
    assign cos_rom[g] = sine64(6'(PHASE + 16));
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  assign add_sum = ACC_W'(bre_q[k_q]) + (ACC_W'(delta_q) <<< FRAC_SH);

  // operand routing for the four real products of one bin
  always_comb begin
    mac_x   = a_q;
    mac_y   = c_q;
    mac_ctl = '{valid: 1'b0, dst_im: 1'b0, op: MAC_LOAD};
    case (state_q)
      S_MUL0: begin
        mac_ctl = '{valid: 1'b1, dst_im: 1'b0, op: MAC_LOAD};
      end
      S_MUL1: begin
        mac_x   = b_q;
        mac_y   = d_q;
        mac_ctl = '{valid: 1'b1, dst_im: 1'b0, op: MAC_SUB};
      end
      S_MUL2: begin
        mac_y   = d_q;
        mac_ctl = '{valid: 1'b1, dst_im: 1'b1, op: MAC_LOAD};
      end
      S_MUL3: begin
        mac_x   = b_q;
        mac_ctl = '{valid: 1'b1, dst_im: 1'b1, op: MAC_ADD};
      end
      default: begin
        mac_x = a_q;
      end
    endcase
  end

  sdft_cmac u_cmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .x_i    (mac_x),
    .y_i    (mac_y),
    .re_o   (mac_re),
    .im_o   (mac_im)
  );

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_PREP;
          k_d     = '0;
        end
      end
      S_PREP:  state_d = S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_MUL3;
      S_MUL3:  state_d = S_DRAIN;
      S_DRAIN: state_d = S_ROUND;
      S_ROUND: state_d = S_OUT;
      S_OUT: begin
        if (out_xfer) begin
          if (k_q == K_LAST) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_PREP;
            k_d     = k_q + KW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      ptr_q   <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        ring_q[i] <= '0;
        bre_q[i]  <= '0;
        bim_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (in_xfer) begin
        ring_q[ptr_q] <= sample_i;
        ptr_q         <= (ptr_q == K_LAST) ? '0 : ptr_q + KW'(1);
      end
      if (state_q == S_ROUND) begin
        bre_q[k_q] <= mac_re;
        bim_q[k_q] <= mac_im;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      delta_q <= $signed({1'b0, sample_i} - {1'b0, ring_q[ptr_q]});
    end
    if (state_q == S_PREP) begin
      a_q <= sat_bin(add_sum);
      b_q <= bim_q[k_q];
      c_q <= cos_rom[k_q];
      d_q <= sin_rom[k_q];
    end
    if (state_q == S_ROUND) begin
      res_re_q <= mac_re;
      res_im_q <= mac_im;
    end
  end

  assign k_wide      = (KW + IDX_W)'(k_q);
  assign bin_index_o = k_wide[IDX_W-1:0];
  assign bin_real_o  = res_re_q;
  assign bin_imag_o  = res_im_q;
  assign last_bin_o  = (k_q == K_LAST);

endmodule

>>> design/sdft_chk.sv
// ----------------------------------------------------------------------------
// sdft_chk
// Port-level checks for the sliding DFT bin update, bound to the top level.
// ----------------------------------------------------------------------------
module sdft_chk #(
  parameter int unsigned WINDOW_SIZE = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [sdft_pkg::IDX_W-1:0]           bin_index_o,
  input logic signed [sdft_pkg::BIN_W-1:0]    bin_real_o,
  input logic signed [sdft_pkg::BIN_W-1:0]    bin_imag_o,
  input logic                                 last_bin_o
);
  import sdft_pkg::*;

  localparam logic [IDX_W+6:0] LAST_WIDE = (IDX_W + 7)'(WINDOW_SIZE - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = LAST_WIDE[IDX_W-1:0];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_index_o)
      && $stable(bin_real_o) && $stable(bin_imag_o) && $stable(last_bin_o))
    else $error("result changed while stalled");

  // busy between samples: never offering a result and taking a sample at once
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // an accepted sample makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("ready right after a sample transfer");

  // last marker only on the final bin
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_bin_o |-> bin_index_o == LAST_IDX)
    else $error("last bin marker on wrong bin");

  // more bins follow a non-final transfer
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_bin_o |=> !in_ready_o)
    else $error("sample accepted before all bins were sent");

endmodule

bind sliding_dft_update sdft_chk #(.WINDOW_SIZE(WINDOW_SIZE)) u_sdft_chk (.*);
